>>> hw/rtl/sbcm_pkg.sv
`timescale 1ns / 1ps

package sbcm_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int DIM_W     = 13;
    localparam int CNT_W     = 12;
    localparam int COORD_W   = 16;
    localparam int ANCHOR_W  = 14;
    localparam int ADDR_W    = 24;
    localparam int COLOR_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPRITE_W = 3'd0,
        CFG_SPRITE_H = 3'd1,
        CFG_ANCHOR_X = 3'd2,
        CFG_ANCHOR_Y = 3'd3,
        CFG_MIRROR   = 3'd4,
        CFG_CANVAS_W = 3'd5,
        CFG_CANVAS_H = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [COLOR_W-1:0] src_color;
        logic               first_pixel;
    } t_in;

    typedef struct packed {
        logic [CNT_W-1:0]   dest_x;
        logic [CNT_W-1:0]   dest_y;
        logic [ADDR_W-1:0]  write_address;
        logic [COLOR_W-1:0] pixel_color;
    } t_out;

    // clamped geometry handed to the placement stage
    typedef struct packed {
        logic [DIM_W-1:0]           sprite_w;
        logic [DIM_W-1:0]           sprite_h;
        logic signed [ANCHOR_W-1:0] anchor_x;
        logic signed [ANCHOR_W-1:0] anchor_y;
        logic                       mirror;
        logic [DIM_W-1:0]           canvas_w;
        logic [DIM_W-1:0]           canvas_h;
    } t_geom;

    typedef struct packed {
        logic [CNT_W-1:0]   dx;
        logic [CNT_W-1:0]   dy;
        logic [COLOR_W-1:0] color;
    } t_place;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/sprite_blit_clip_mirror_top.sv
`timescale 1ns / 1ps

// channel   dir  handshake                     payload
// in        in   i_in_valid / o_in_ready       i_in_data  (t_in)
// out       out  o_out_valid / i_out_ready     o_out_data (t_out)
// cfg       in   i_cfg_we                      i_cfg_idx, i_cfg_data
//
// One pixel per clock while the output is not stalled. An accepted pixel passes
// the input register, placement and clip into the second register, then the
// address multiply into the output register, which drives o_out_valid.
// Transparent or clipped pixels give no beat.
// Synchronous active-low reset clears counters, valids and the config registers
// to their defaults. A stall on the output backs up through the pipeline.

module sprite_blit_clip_mirror_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  sbcm_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output sbcm_pkg::t_out                     o_out_data,
    input  logic                               i_cfg_we,
    input  logic [sbcm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sbcm_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import sbcm_pkg::*;

    logic [DIM_W-1:0]           r_sprite_w;
    logic [DIM_W-1:0]           r_sprite_h;
    logic signed [ANCHOR_W-1:0] r_anchor_x;
    logic signed [ANCHOR_W-1:0] r_anchor_y;
    logic                       r_mirror;
    logic [DIM_W-1:0]           r_canvas_w;
    logic [DIM_W-1:0]           r_canvas_h;

    logic [CNT_W-1:0] r_src_col;
    logic [CNT_W-1:0] r_src_row;
    logic [CNT_W-1:0] n_src_col;
    logic [CNT_W-1:0] n_src_row;
    logic [CNT_W-1:0] cur_col;
    logic [CNT_W-1:0] cur_row;

    logic  r_out_valid;
    t_out  r_out;

    t_geom  geom;
    t_place place;
    logic   place_valid;
    logic   out_en;
    logic   in_acc;
    logic [ADDR_W:0] addr_full;

    assign geom.sprite_w = clamp_dim(r_sprite_w);
    assign geom.sprite_h = clamp_dim(r_sprite_h);
    assign geom.anchor_x = r_anchor_x;
    assign geom.anchor_y = r_anchor_y;
    assign geom.mirror   = r_mirror;
    assign geom.canvas_w = clamp_dim(r_canvas_w);
    assign geom.canvas_h = clamp_dim(r_canvas_h);

    assign in_acc      = i_in_valid && o_in_ready;
    assign out_en      = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        cur_col = i_in_data.first_pixel ? '0 : r_src_col;
        cur_row = i_in_data.first_pixel ? '0 : r_src_row;
        if (({1'b0, cur_col} + DIM_W'(1)) >= geom.sprite_w) begin
            n_src_col = '0;
            n_src_row = (({1'b0, cur_row} + DIM_W'(1)) >= geom.sprite_h) ?
                        '0 : cur_row + CNT_W'(1);
        end else begin
            n_src_col = cur_col + CNT_W'(1);
            n_src_row = cur_row;
        end
    end

    sbcm_place u_place (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (geom),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_color (i_in_data.src_color),
        .i_col   (cur_col),
        .i_row   (cur_row),
        .o_valid (place_valid),
        .i_ready (out_en),
        .o_place (place)
    );

    assign addr_full = ({(ADDR_W+1-CNT_W)'(0), place.dy} * (ADDR_W+1)'(geom.canvas_w))
                     + {(ADDR_W+1-CNT_W)'(0), place.dx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sprite_w  <= DIM_W'(1);
            r_sprite_h  <= DIM_W'(1);
            r_anchor_x  <= '0;
            r_anchor_y  <= '0;
            r_mirror    <= 1'b0;
            r_canvas_w  <= DIM_W'(1);
            r_canvas_h  <= DIM_W'(1);
            r_src_col   <= '0;
            r_src_row   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_SPRITE_W: begin
                        r_sprite_w <= i_cfg_data[DIM_W-1:0];
                    end
                    CFG_SPRITE_H: begin
                        r_sprite_h <= i_cfg_data[DIM_W-1:0];
                    end
                    CFG_ANCHOR_X: begin
                        r_anchor_x <= $signed(i_cfg_data[ANCHOR_W-1:0]);
                    end
                    CFG_ANCHOR_Y: begin
                        r_anchor_y <= $signed(i_cfg_data[ANCHOR_W-1:0]);
                    end
                    CFG_MIRROR: begin
                        r_mirror <= i_cfg_data[0];
                    end
                    CFG_CANVAS_W: begin
                        r_canvas_w <= i_cfg_data[DIM_W-1:0];
                    end
                    CFG_CANVAS_H: begin
                        r_canvas_h <= i_cfg_data[DIM_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (in_acc) begin
                r_src_col <= n_src_col;
                r_src_row <= n_src_row;
            end
            if (out_en) begin
                r_out_valid <= place_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en) begin
            r_out.dest_x        <= place.dx;
            r_out.dest_y        <= place.dy;
            r_out.write_address <= addr_full[ADDR_W-1:0];
            r_out.pixel_color   <= place.color;
        end
    end

    a_out_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.pixel_color != '0)
        else $error("transparent pixel written");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_first_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.first_pixel && (geom.sprite_w > DIM_W'(1))
        |=> r_src_col == CNT_W'(1))
        else $error("column counter not restarted by first pixel");

    a_first_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.first_pixel && (geom.sprite_w == DIM_W'(1))
        && (geom.sprite_h == DIM_W'(1))
        |=> r_src_col == '0 && r_src_row == '0)
        else $error("single pixel sprite did not wrap");

endmodule

>>> hw/rtl/sbcm_place.sv
`timescale 1ns / 1ps

module sbcm_place (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sbcm_pkg::t_geom         i_geom,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [31:0]             i_color,
    input  logic [11:0]             i_col,
    input  logic [11:0]             i_row,
    output logic                    o_valid,
    input  logic                    i_ready,
    output sbcm_pkg::t_place        o_place
);
    import sbcm_pkg::*;

    logic               r_s1_valid;
    logic [COLOR_W-1:0] r_s1_color;
    logic [CNT_W-1:0]   r_s1_col;
    logic [CNT_W-1:0]   r_s1_row;
    logic               r_s2_valid;
    t_place             r_s2;

    logic s1_en;
    logic s2_en;

    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] w_s;
    logic signed [COORD_W-1:0] half_w;
    logic signed [COORD_W-1:0] half_h;
    logic signed [COORD_W-1:0] col_s;
    logic signed [COORD_W-1:0] row_s;
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] n_dx;
    logic signed [COORD_W-1:0] n_dy;
    logic                      vis;

    assign s2_en   = !r_s2_valid || i_ready;
    assign s1_en   = !r_s1_valid || s2_en;
    assign o_ready = s1_en;
    assign o_valid = r_s2_valid;
    assign o_place = r_s2;

    always_comb begin
        ax     = COORD_W'(i_geom.anchor_x);
        ay     = COORD_W'(i_geom.anchor_y);
        w_s    = $signed(COORD_W'(i_geom.sprite_w));
        half_w = $signed(COORD_W'(i_geom.sprite_w[DIM_W-1:1]));
        half_h = $signed(COORD_W'(i_geom.sprite_h[DIM_W-1:1]));
        col_s  = $signed(COORD_W'(r_s1_col));
        row_s  = $signed(COORD_W'(r_s1_row));
        left   = ax - half_w;
        top    = ay - half_h;
        n_dx   = i_geom.mirror ? (left + w_s - 16'sd1 - col_s) : (left + col_s);
        n_dy   = top + row_s;
        vis    = ({1'b0, r_s1_col} < i_geom.sprite_w)
              && ({1'b0, r_s1_row} < i_geom.sprite_h)
              && (r_s1_color != '0)
              && !n_dx[COORD_W-1]
              && (n_dx[COORD_W-2:0] < (COORD_W-1)'(i_geom.canvas_w))
              && !n_dy[COORD_W-1]
              && (n_dy[COORD_W-2:0] < (COORD_W-1)'(i_geom.canvas_h));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_en) begin
                r_s1_valid <= i_valid;
            end
            if (s2_en) begin
                r_s2_valid <= r_s1_valid && vis;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_s1_color <= i_color;
            r_s1_col   <= i_col;
            r_s1_row   <= i_row;
        end
        if (s2_en) begin
            r_s2.dx    <= n_dx[CNT_W-1:0];
            r_s2.dy    <= n_dy[CNT_W-1:0];
            r_s2.color <= r_s1_color;
        end
    end

    // transparent pixels never reach the second stage
    a_s2_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> r_s2.color != '0)
        else $error("transparent pixel in placement stage");

    // a stalled second stage keeps its beat
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && !i_ready |=> r_s2_valid && $stable(r_s2))
        else $error("placement beat lost under stall");

endmodule

>>> sim/sprite_blit_clip_mirror_top_test.sv
`timescale 1ns / 1ps

module sprite_blit_clip_mirror_top_test;
    import sbcm_pkg::*;

    localparam int WATCHDOG_CYCLES = 600000;
    localparam int SETTLE_CYCLES   = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in                   in_data;
    logic                  out_valid;
    logic                  out_ready = 1'b1;
    t_out                  out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DAT_W-1:0]  cfg_data;

    // shadow copy of the register file
    logic [DIM_W-1:0]           m_sprite_w;
    logic [DIM_W-1:0]           m_sprite_h;
    logic signed [ANCHOR_W-1:0] m_anchor_x;
    logic signed [ANCHOR_W-1:0] m_anchor_y;
    logic                       m_mirror;
    logic [DIM_W-1:0]           m_canvas_w;
    logic [DIM_W-1:0]           m_canvas_h;

    // source raster position of the next pixel
    int blit_col;
    int blit_row;

    t_out canvas_writes_due[$];
    t_out due;
    int   failures;
    int   send_idle_pct;
    int   stall_pct;
    bit   draining;

    sprite_blit_clip_mirror_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int dim_eff(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(v);
    endfunction

    function automatic void blit_reset();
        m_sprite_w = DIM_W'(1);
        m_sprite_h = DIM_W'(1);
        m_anchor_x = '0;
        m_anchor_y = '0;
        m_mirror   = 1'b0;
        m_canvas_w = DIM_W'(1);
        m_canvas_h = DIM_W'(1);
        blit_col   = 0;
        blit_row   = 0;
    endfunction

    function automatic bit place_pixel(input t_in px, output t_out wr);
        int w, h, cw, ch, left, top, dx, dy;
        bit hit;
        w  = dim_eff(m_sprite_w);
        h  = dim_eff(m_sprite_h);
        cw = dim_eff(m_canvas_w);
        ch = dim_eff(m_canvas_h);
        if (px.first_pixel) begin
            blit_col = 0;
            blit_row = 0;
        end
        left = int'(m_anchor_x) - (w >> 1);
        top  = int'(m_anchor_y) - (h >> 1);
        dx   = m_mirror ? left + w - 1 - blit_col : left + blit_col;
        dy   = top + blit_row;
        hit  = blit_col < w && blit_row < h && px.src_color != '0 &&
               dx >= 0 && dx < cw && dy >= 0 && dy < ch;
        wr.dest_x        = CNT_W'(dx);
        wr.dest_y        = CNT_W'(dy);
        wr.write_address = ADDR_W'(dy * cw + dx);
        wr.pixel_color   = px.src_color;
        if (blit_col + 1 >= w) begin
            blit_col = 0;
            blit_row = (blit_row + 1 >= h) ? 0 : ((blit_row + 1) & 12'hFFF);
        end else begin
            blit_col = (blit_col + 1) & 12'hFFF;
        end
        return hit;
    endfunction

    task automatic set_reg(input t_cfg_idx idx, input logic [CFG_DAT_W-1:0] val);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        case (idx)
            CFG_SPRITE_W: m_sprite_w = val[DIM_W-1:0];
            CFG_SPRITE_H: m_sprite_h = val[DIM_W-1:0];
            CFG_ANCHOR_X: m_anchor_x = val;
            CFG_ANCHOR_Y: m_anchor_y = val;
            CFG_MIRROR:   m_mirror   = val[0];
            CFG_CANVAS_W: m_canvas_w = val[DIM_W-1:0];
            CFG_CANVAS_H: m_canvas_h = val[DIM_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        in_valid = 1'b0;
        draining = 1'b1;
        while (canvas_writes_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        draining = 1'b0;
    endtask

    task automatic program_regs(input logic [CFG_DAT_W-1:0] sw, input logic [CFG_DAT_W-1:0] sh,
                                input logic [CFG_DAT_W-1:0] ax, input logic [CFG_DAT_W-1:0] ay,
                                input logic [CFG_DAT_W-1:0] mir,
                                input logic [CFG_DAT_W-1:0] cw, input logic [CFG_DAT_W-1:0] ch);
        drain_pipeline();
        set_reg(CFG_SPRITE_W, sw);
        set_reg(CFG_SPRITE_H, sh);
        set_reg(CFG_ANCHOR_X, ax);
        set_reg(CFG_ANCHOR_Y, ay);
        set_reg(CFG_MIRROR, mir);
        set_reg(CFG_CANVAS_W, cw);
        set_reg(CFG_CANVAS_H, ch);
    endtask

    task automatic send_pixel(input logic [COLOR_W-1:0] color, input logic first);
        t_in  beat;
        t_out wr;
        beat.src_color   = color;
        beat.first_pixel = first;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = beat;
        do @(posedge clk); while (!in_ready);
        if (place_pixel(beat, wr)) begin
            canvas_writes_due.push_back(wr);
        end
    endtask

    function automatic logic [COLOR_W-1:0] rand_color();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) return '0;
        if (pick < 30) return '1;
        if (pick < 35) return COLOR_W'(1);
        return $urandom;
    endfunction

    function automatic logic [CFG_DAT_W-1:0] rand_sprite_dim();
        int pick;
        logic [CFG_DAT_W-1:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 85)      v = CFG_DAT_W'($urandom_range(1, 12));
        else if (pick < 90) v = '0;
        else if (pick < 95) v = CFG_DAT_W'($urandom_range(13, 64));
        else if (pick < 97) v = CFG_DAT_W'(MAX_DIM);
        else                v = CFG_DAT_W'($urandom_range(MAX_DIM + 1, 8191));
        if ($urandom_range(0, 9) == 0) v[CFG_DAT_W-1] = 1'b1;
        return v;
    endfunction

    function automatic logic [CFG_DAT_W-1:0] rand_canvas_dim();
        int pick;
        logic [CFG_DAT_W-1:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 70)      v = CFG_DAT_W'($urandom_range(1, 40));
        else if (pick < 90) v = CFG_DAT_W'($urandom_range(41, MAX_DIM));
        else if (pick < 95) v = '0;
        else                v = CFG_DAT_W'($urandom_range(MAX_DIM + 1, 8191));
        if ($urandom_range(0, 9) == 0) v[CFG_DAT_W-1] = 1'b1;
        return v;
    endfunction

    function automatic logic [CFG_DAT_W-1:0] rand_anchor(input int span);
        if ($urandom_range(0, 99) < 80) begin
            return CFG_DAT_W'(int'($urandom_range(0, span + 16)) - 8);
        end
        return CFG_DAT_W'($urandom);
    endfunction

    task automatic test_reset_defaults();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_pixel(32'h0000_0001, 1'b1);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);
    endtask

    task automatic test_raster_and_mirror();
        int k;
        program_regs(3, 2, 4, 4, 0, 8, 8);
        for (k = 0; k < 6; k++) send_pixel((k == 4) ? 32'h0 : 32'hA500_0000 + k, k == 0);
        // wraps back to the origin without a mark
        program_regs(3, 2, 4, 4, 1, 8, 8);
        for (k = 0; k < 3; k++) send_pixel(32'h5A00_0010 + k, 1'b0);
    endtask

    task automatic test_clip_edges();
        int k;
        program_regs(2, 2, 0, 0, 0, 1, 1);
        for (k = 0; k < 4; k++) send_pixel(32'hC0DE_0000 + k, k == 0);
        program_regs(1, 1, 4095, 4095, 0, CFG_DAT_W'(MAX_DIM), CFG_DAT_W'(MAX_DIM));
        send_pixel(32'hFFFF_FFFF, 1'b1);
        program_regs(1, 1, 14'h2000, 14'h2000, 0, CFG_DAT_W'(MAX_DIM), CFG_DAT_W'(MAX_DIM));
        send_pixel(32'h1234_5678, 1'b1);
        program_regs(1, 1, 14'h1FFF, 14'h1FFF, 1, CFG_DAT_W'(MAX_DIM), CFG_DAT_W'(MAX_DIM));
        send_pixel(32'h8765_4321, 1'b1);
    endtask

    task automatic test_dim_clamp();
        int k;
        program_regs(0, 8191, 0, 2048, 0, 0, 8191);
        for (k = 0; k < 3; k++) send_pixel(32'h0D00_0000 + k, k == 0);
        program_regs(8191, 1, 2048, 0, 1, 8191, 1);
        for (k = 0; k < 2; k++) send_pixel(32'h0E00_0000 + k, k == 0);
    endtask

    task automatic test_counter_outside_sprite();
        int k;
        program_regs(4, 2, 4, 4, 0, 8, 8);
        for (k = 0; k < 3; k++) send_pixel(32'h0F00_0000 + k, k == 0);
        // column now beyond the narrower sprite
        program_regs(2, 2, 4, 4, 0, 8, 8);
        for (k = 0; k < 2; k++) send_pixel(32'h0F10_0000 + k, 1'b0);
        program_regs(1, 4, 4, 4, 0, 8, 8);
        for (k = 0; k < 3; k++) send_pixel(32'h0F20_0000 + k, k == 0);
        // row now beyond the shorter sprite
        program_regs(1, 2, 4, 4, 0, 8, 8);
        for (k = 0; k < 2; k++) send_pixel(32'h0F30_0000 + k, 1'b0);
    endtask

    task automatic test_wide_sprite();
        int k;
        send_idle_pct = 0;
        stall_pct     = 0;
        program_regs(CFG_DAT_W'(MAX_DIM), 2, 2048, 1, 0, CFG_DAT_W'(MAX_DIM), 2);
        for (k = 0; k < 150; k++) send_pixel(rand_color(), k == 0);
        program_regs(CFG_DAT_W'(MAX_DIM), 2, 2048, 1, 1, CFG_DAT_W'(MAX_DIM), 2);
        for (k = 0; k < 48; k++) send_pixel(rand_color(), k == 0);
    endtask

    task automatic test_random_blits(input int n_items, input int idle_pct, input int stall);
        int sent, n_px, w, h, k;
        logic [CFG_DAT_W-1:0] sw, sh, cw, ch, ax, ay, mir;
        logic first;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        sent          = 0;
        while (sent < n_items) begin
            sw  = rand_sprite_dim();
            sh  = rand_sprite_dim();
            cw  = rand_canvas_dim();
            ch  = rand_canvas_dim();
            ax  = rand_anchor(dim_eff(cw[DIM_W-1:0]));
            ay  = rand_anchor(dim_eff(ch[DIM_W-1:0]));
            mir = ($urandom_range(0, 9) == 0) ? CFG_DAT_W'($urandom)
                                              : CFG_DAT_W'($urandom_range(0, 1));
            program_regs(sw, sh, ax, ay, mir, cw, ch);
            w    = dim_eff(sw[DIM_W-1:0]);
            h    = dim_eff(sh[DIM_W-1:0]);
            n_px = w * h;
            if (n_px > 96) begin
                n_px = $urandom_range(1, 96);
            end else if ($urandom_range(0, 9) == 0) begin
                n_px = $urandom_range(1, n_px);
            end else if ($urandom_range(0, 9) == 0 && n_px <= 48) begin
                n_px = 2 * n_px;
            end
            for (k = 0; k < n_px; k++) begin
                first = (k == 0 && $urandom_range(0, 99) < 85) || $urandom_range(0, 99) < 2;
                send_pixel(rand_color(), first);
            end
            sent += n_px;
        end
    endtask

    always @(negedge clk) begin
        if (!rst_n || draining) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (canvas_writes_due.size() == 0) begin
                if (failures < 10) begin
                    $display("unexpected write beat: x=%0d y=%0d addr=%0d color=%h",
                             out_data.dest_x, out_data.dest_y,
                             out_data.write_address, out_data.pixel_color);
                end
                failures++;
            end else begin
                due = canvas_writes_due.pop_front();
                if (out_data.dest_x !== due.dest_x || out_data.dest_y !== due.dest_y ||
                    out_data.write_address !== due.write_address ||
                    out_data.pixel_color !== due.pixel_color) begin
                    if (failures < 10) begin
                        $display("write mismatch: exp x=%0d y=%0d addr=%0d color=%h",
                                 due.dest_x, due.dest_y, due.write_address, due.pixel_color);
                        $display("                got x=%0d y=%0d addr=%0d color=%h",
                                 out_data.dest_x, out_data.dest_y,
                                 out_data.write_address, out_data.pixel_color);
                    end
                    failures++;
                end
            end
        end
    end

    initial begin
        repeat (WATCHDOG_CYCLES) @(posedge clk);
        $display("[sprite_blit_clip_mirror_top] ERROR");
        $finish;
    end

    initial begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_SPRITE_W;
        cfg_data      = '0;
        failures      = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        draining      = 1'b0;
        blit_reset();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_raster_and_mirror();
        test_clip_edges();
        test_dim_clamp();
        test_counter_outside_sprite();
        test_wide_sprite();
        test_random_blits(340, 0, 0);
        test_random_blits(340, 86, 0);
        test_random_blits(340, 0, 86);
        test_random_blits(340, 32, 32);
        drain_pipeline();

        if (failures == 0) begin
            $display("[sprite_blit_clip_mirror_top] OK");
        end else begin
            $display("[sprite_blit_clip_mirror_top] ERROR");
        end
        $finish;
    end

endmodule
